[sv/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Character codes, the command record that flows from the front end to the
// back end, and the back-end state encoding.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  // Entries in the command queue between the front and the back end.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ
  } tcw_op_e;

  // Memory work plus the result fields that the front end already knows.
  typedef struct packed {
    tcw_op_e     op;
    logic [15:0] wdata;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        scrolled;
  } tcw_cmd_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_DONE
  } tcw_state_e;

endpackage

[sv/tcw_ram.sv]
// ----------------------------------------------------------------------------
// tcw_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/tcw_front.sv]
// ----------------------------------------------------------------------------
// tcw_front: command intake and cursor tracking
// Accepts commands, classifies them, advances the cursor and the scroll
// origin, and hands a memory command with its result fields to the queue.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int AW     = $clog2(ROWS * COLUMNS),
  localparam int RW     = $clog2(ROWS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          cmd_i,
  input  logic [7:0]    character_i,
  input  logic [7:0]    color_i,
  input  logic [6:0]    col_i,
  input  logic [4:0]    row_i,
  input  logic          init_busy_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output tcw_cmd_t      q_cmd_o,
  output logic [AW-1:0] q_addr_o,
  output logic [RW-1:0] q_clr_row_o
);

  localparam int CW  = $clog2(COLUMNS);
  localparam int RSW = ((RW > 5) ? RW : 5) + 1;
  localparam int CSW = ((CW > 7) ? CW : 7) + 1;

  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [RW-1:0]  top_q, top_d;
  logic           accept;
  logic           is_cr, is_lf, put_char;
  logic           col_last, row_last, move_down, scroll, read_ok;
  logic [RSW-1:0] sel_row, row_sum, phys_row_w;
  logic [CSW-1:0] sel_col;
  logic [RW-1:0]  phys_row;

  assign in_ready_o = q_ready_i && !init_busy_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_valid_o  = accept;

  assign is_cr    = (character_i == CH_CR);
  assign is_lf    = (character_i == CH_LF);
  assign put_char = !cmd_i && !is_cr && !is_lf;
  assign col_last = (col_q == CW'(COLUMNS - 1));
  assign row_last = (row_q == RW'(ROWS - 1));

  assign move_down = !cmd_i && (is_lf || (put_char && col_last));
  assign scroll    = move_down && row_last;
  assign read_ok   = (CSW'(col_i) < CSW'(COLUMNS)) && (RSW'(row_i) < RSW'(ROWS));

  always_comb begin
    col_d = col_q;
    if (!cmd_i) begin
      if (is_cr || is_lf || col_last) begin
        col_d = '0;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  assign row_d = (move_down && !row_last) ? row_q + 1'b1 : row_q;
  assign top_d = !scroll ? top_q :
                 (top_q == RW'(ROWS - 1)) ? '0 : top_q + 1'b1;

  // Screen rows live in the RAM as a ring; top_q is the physical row of the
  // first visible line, so a scroll only moves the origin and clears a row.
  assign sel_row    = cmd_i ? RSW'(row_i) : RSW'(row_q);
  assign sel_col    = cmd_i ? CSW'(col_i) : CSW'(col_q);
  assign row_sum    = sel_row + RSW'(top_q);
  assign phys_row_w = (row_sum >= RSW'(ROWS)) ? row_sum - RSW'(ROWS) : row_sum;
  assign phys_row   = RW'(phys_row_w);

  assign q_addr_o    = AW'(phys_row) * AW'(COLUMNS) + AW'(sel_col);
  assign q_clr_row_o = top_q;

  always_comb begin
    q_cmd_o.op = OP_NONE;
    if (cmd_i) begin
      if (read_ok) begin
        q_cmd_o.op = OP_READ;
      end
    end else if (put_char) begin
      q_cmd_o.op = OP_WRITE;
    end
    q_cmd_o.wdata      = {color_i, character_i};
    q_cmd_o.cursor_col = 7'(col_d);
    q_cmd_o.cursor_row = 5'(row_d);
    q_cmd_o.scrolled   = scroll;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      top_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
      top_q <= top_d;
    end
  end

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CSW'(col_q) < CSW'(COLUMNS)) && (RSW'(row_q) < RSW'(ROWS)) &&
    (RSW'(top_q) < RSW'(ROWS)))
    else $error("cursor or scroll origin out of range");

  a_cr_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !cmd_i && is_cr |=> (col_q == '0) && (row_q == $past(row_q)))
    else $error("carriage return did not home the column");

  a_scroll_moves_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && scroll |=> (row_q == RW'(ROWS - 1)) && (top_q != $past(top_q)))
    else $error("scroll did not advance the ring origin");

endmodule

[sv/tcw_queue.sv]
// ----------------------------------------------------------------------------
// tcw_queue: small command FIFO
// Decouples the front end from the back end so each can stall on its own.
// ----------------------------------------------------------------------------
module tcw_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [W-1:0]   mem_q [DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CNW-1:0] cnt_q;
  logic           push, pop;

  assign push_ready_o = (cnt_q != CNW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[sv/tcw_back.sv]
// ----------------------------------------------------------------------------
// tcw_back: cell store and command execution
// Owns the cell RAM: clears it after reset, performs writes and reads,
// clears the recycled row on a scroll, and drives the result register.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int AW     = $clog2(ROWS * COLUMNS),
  localparam int RW     = $clog2(ROWS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  tcw_cmd_t      q_cmd_i,
  input  logic [AW-1:0] q_addr_i,
  input  logic [RW-1:0] q_clr_row_i,
  output logic          init_busy_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    cell_char_o,
  output logic [7:0]    cell_color_o,
  output logic [6:0]    cursor_col_o,
  output logic [4:0]    cursor_row_o,
  output logic          scrolled_o
);

  localparam int CELLS = ROWS * COLUMNS;

  tcw_state_e    state_q, state_d;
  tcw_cmd_t      cur_q;
  logic [AW-1:0] base_q;
  logic [AW-1:0] sweep_q, sweep_d;
  logic          sweep_last, slot_free, pop, direct;
  logic          out_load, out_from_cur;
  logic          out_valid_q;
  logic [7:0]    cell_char_q, cell_color_q;
  logic [6:0]    cursor_col_q;
  logic [4:0]    cursor_row_q;
  logic          scrolled_q;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata, ram_rdata;

  tcw_ram #(
    .W    (16),
    .DEPTH(CELLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(q_addr_i),
    .rdata_o(ram_rdata)
  );

  assign sweep_last = (state_q == ST_INIT) ? (sweep_q == AW'(CELLS - 1)) :
                                             (sweep_q == AW'(COLUMNS - 1));
  assign slot_free  = !out_valid_q || out_ready_i;
  assign q_ready_o  = (state_q == ST_IDLE);
  assign pop        = q_ready_o && q_valid_i;
  // A plain print or empty read finishes in its pop cycle if the slot is free.
  assign direct     = pop && !q_cmd_i.scrolled && (q_cmd_i.op != OP_READ) && slot_free;
  assign init_busy_o = (state_q == ST_INIT);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_cmd_i.scrolled) begin
            state_d = ST_CLEAR;
          end else if (!direct) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_CLEAR: begin
        if (sweep_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = q_addr_i;
    ram_wdata    = q_cmd_i.wdata;
    out_load     = 1'b0;
    out_from_cur = 1'b0;
    sweep_d      = sweep_q;
    case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = '0;
        sweep_d   = sweep_last ? '0 : sweep_q + 1'b1;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          ram_we   = (q_cmd_i.op == OP_WRITE);
          ram_re   = (q_cmd_i.op == OP_READ);
          out_load = direct;
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = base_q + sweep_q;
        ram_wdata = '0;
        sweep_d   = sweep_last ? '0 : sweep_q + 1'b1;
      end
      ST_DONE: begin
        out_load     = slot_free;
        out_from_cur = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q  <= q_cmd_i;
      base_q <= AW'(q_clr_row_i) * AW'(COLUMNS);
    end
    if (out_load) begin
      if (out_from_cur && (cur_q.op == OP_READ)) begin
        cell_char_q  <= ram_rdata[7:0];
        cell_color_q <= ram_rdata[15:8];
      end else begin
        cell_char_q  <= '0;
        cell_color_q <= '0;
      end
      cursor_col_q <= out_from_cur ? cur_q.cursor_col : q_cmd_i.cursor_col;
      cursor_row_q <= out_from_cur ? cur_q.cursor_row : q_cmd_i.cursor_row;
      scrolled_q   <= out_from_cur ? cur_q.scrolled : q_cmd_i.scrolled;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_char_o  = cell_char_q;
  assign cell_color_o = cell_color_q;
  assign cursor_col_o = cursor_col_q;
  assign cursor_row_o = cursor_row_q;
  assign scrolled_o   = scrolled_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");

  a_clear_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (sweep_q < AW'(COLUMNS)))
    else $error("row clear ran past the last column");

  a_init_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_INIT) |=> (state_q != ST_INIT))
    else $error("clearing pass restarted without reset");

  a_read_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && (q_cmd_i.op == OP_READ) |=> (state_q == ST_DONE))
    else $error("read result not taken from registered RAM data");

endmodule

[sv/text_console_writer_core.sv]
// ----------------------------------------------------------------------------
// text_console_writer_core: text-mode console with cursor and scrolling
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   cmd, character, color, col, row
// out      output     out_valid_o / out_ready_i cell_char, cell_color,
//                                                cursor_col, cursor_row, scrolled
//
// A print without scroll loads the result in its pop cycle if the result
// slot is free; a read first goes to ST_DONE (the cell RAM has a registered
// read port). A scroll clears the COLUMNS cells of the recycled row in
// ST_CLEAR through the single RAM write port, then loads the result in ST_DONE.
// After reset the RAM is cleared one cell a cycle, all ROWS*COLUMNS cells
// (2000 at the default size), and in_ready_o stays low meanwhile.
// A two-entry queue lets the front end keep taking transactions while the
// back end clears a row or the result waits on out_ready_i.
// ----------------------------------------------------------------------------
module text_console_writer_core import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [7:0] character_i,
  input  logic [7:0] color_i,
  input  logic [6:0] col_i,
  input  logic [4:0] row_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] cell_char_o,
  output logic [7:0] cell_color_o,
  output logic [6:0] cursor_col_o,
  output logic [4:0] cursor_row_o,
  output logic       scrolled_o
);

  localparam int AW = $clog2(ROWS * COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam int QW = $bits(tcw_cmd_t) + AW + RW;

  logic          init_busy;
  logic          f_valid, f_ready, b_valid, b_ready;
  tcw_cmd_t      f_cmd, b_cmd;
  logic [AW-1:0] f_addr, b_addr;
  logic [RW-1:0] f_clr_row, b_clr_row;
  logic [QW-1:0] push_data, pop_data;

  tcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .character_i(character_i),
    .color_i    (color_i),
    .col_i      (col_i),
    .row_i      (row_i),
    .init_busy_i(init_busy),
    .q_valid_o  (f_valid),
    .q_ready_i  (f_ready),
    .q_cmd_o    (f_cmd),
    .q_addr_o   (f_addr),
    .q_clr_row_o(f_clr_row)
  );

  assign push_data = {f_cmd, f_addr, f_clr_row};
  assign {b_cmd, b_addr, b_clr_row} = pop_data;

  tcw_queue #(
    .W    (QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_data_i (push_data),
    .pop_valid_o (b_valid),
    .pop_ready_i (b_ready),
    .pop_data_o  (pop_data)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (b_valid),
    .q_ready_o   (b_ready),
    .q_cmd_i     (b_cmd),
    .q_addr_i    (b_addr),
    .q_clr_row_i (b_clr_row),
    .init_busy_o (init_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cell_char_o (cell_char_o),
    .cell_color_o(cell_color_o),
    .cursor_col_o(cursor_col_o),
    .cursor_row_o(cursor_row_o),
    .scrolled_o  (scrolled_o)
  );

endmodule
